/* rtl/cfpx_pkg.sv */
// Shared types and constants for the command frame parser with XOR check.
package cfpx_pkg;

   localparam logic [7:0]  CHAR_COMMA   = 8'h2C;
   localparam logic [7:0]  CHAR_MINUS   = 8'h2D;
   localparam logic [7:0]  CHAR_PLUS    = 8'h2B;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [1:0]  LAST_FIELD   = 2'd3;
   localparam logic [2:0]  HEADER_LEN   = 3'd4;
   localparam logic [31:0] HEADER_RESET = 32'h4E4A5545;

   typedef struct packed {
      logic [7:0] text_char;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic signed [15:0] command_number;
      logic [63:0]        data_text;
      logic [3:0]         data_length;
      logic               data_truncated;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_COMMA,
      CLS_DIGIT,
      CLS_MINUS,
      CLS_PLUS
   } char_class_type;

   // A classified character as it travels from the front end to the parser.
   typedef struct packed {
      logic [7:0]     text_char;
      logic           frame_end;
      char_class_type char_class;
      logic [3:0]     digit;
   } item_type;

endpackage

/* rtl/cfpx_front.sv */
// Front end: classifies each incoming character for the parser.
module cfpx_front (
   input  cfpx_pkg::req_type  req_data,
   output cfpx_pkg::item_type item
);
   import cfpx_pkg::*;

   always_comb begin
      item.text_char  = req_data.text_char;
      item.frame_end  = req_data.frame_end;
      item.digit      = 4'(req_data.text_char - CHAR_ZERO);
      case (req_data.text_char) inside
         CHAR_COMMA:             item.char_class = CLS_COMMA;
         CHAR_MINUS:             item.char_class = CLS_MINUS;
         CHAR_PLUS:              item.char_class = CLS_PLUS;
         [CHAR_ZERO:CHAR_NINE]:  item.char_class = CLS_DIGIT;
         default:                item.char_class = CLS_OTHER;
      endcase
   end

endmodule

/* rtl/cfpx_queue.sv */
// Small first-in first-out queue of words built from registers.
module cfpx_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/cfpx_back.sv */
// Back end field parser: updates state a word per cycle unless out_full.
module cfpx_back #(
   parameter int DATA_CHARS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        header_word,
   input  logic               in_empty,
   input  cfpx_pkg::item_type in_item,
   output logic               in_pop,
   input  logic               out_full,
   output logic               out_push,
   output cfpx_pkg::rsp_type  out_item
);
   import cfpx_pkg::*;

   localparam logic [3:0] DATA_MAX  = 4'(DATA_CHARS);
   localparam logic [3:0] DATA_OVER = 4'(DATA_CHARS + 1);

   logic [1:0]  field_index_ff, field_index_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   logic [2:0]  header_pos_ff, header_pos_in;
   logic        header_ok_ff, header_ok_in;
   logic [15:0] number_acc_ff, number_acc_in;
   logic        number_negative_ff, number_negative_in;
   logic [15:0] check_acc_ff, check_acc_in;
   logic [1:0]  digits_seen_ff, digits_seen_in;
   logic [63:0] data_buffer_ff, data_buffer_in;
   logic [3:0]  data_count_ff, data_count_in;

   always_comb begin
      logic [7:0] ch;
      logic [7:0] want;

      ch   = in_item.text_char;
      want = '0;

      field_index_in     = field_index_ff;
      running_xor_in     = running_xor_ff;
      header_pos_in      = header_pos_ff;
      header_ok_in       = header_ok_ff;
      number_acc_in      = number_acc_ff;
      number_negative_in = number_negative_ff;
      check_acc_in       = check_acc_ff;
      digits_seen_in     = digits_seen_ff;
      data_buffer_in     = data_buffer_ff;
      data_count_in      = data_count_ff;

      // A word is taken only when there is room for a possible result.
      in_pop   = !in_empty && !out_full;
      out_push = in_pop && in_item.frame_end;

      if (in_pop) begin
         if (in_item.char_class == CLS_COMMA) begin
            running_xor_in = running_xor_ff ^ ch;
            if (field_index_ff != LAST_FIELD) begin
               field_index_in = field_index_ff + 2'd1;
            end
         end else begin
            if (field_index_ff != LAST_FIELD) begin
               running_xor_in = running_xor_ff ^ ch;
            end
            case (field_index_ff)
               2'd0: begin
                  case (header_pos_ff[1:0])
                     2'd0:    want = header_word[31:24];
                     2'd1:    want = header_word[23:16];
                     2'd2:    want = header_word[15:8];
                     default: want = header_word[7:0];
                  endcase
                  if (header_pos_ff >= HEADER_LEN || ch != want) begin
                     header_ok_in = 1'b0;
                  end
                  if (header_pos_ff <= HEADER_LEN) begin
                     header_pos_in = header_pos_ff + 3'd1;
                  end
               end
               2'd1: begin
                  if (in_item.char_class == CLS_DIGIT) begin
                     number_acc_in = {number_acc_ff[12:0], 3'b000} +
                                     {number_acc_ff[14:0], 1'b0} +
                                     {12'd0, in_item.digit};
                     digits_seen_in[0] = 1'b1;
                  end else if (!digits_seen_ff[0]) begin
                     if (in_item.char_class == CLS_MINUS) begin
                        number_negative_in = 1'b1;
                     end else if (in_item.char_class == CLS_PLUS) begin
                        number_negative_in = 1'b0;
                     end
                  end
               end
               2'd2: begin
                  if (data_count_ff < DATA_MAX) begin
                     for (int i = 0; i < DATA_CHARS; i++) begin
                        if (data_count_ff == 4'(i)) begin
                           data_buffer_in[63 - 8 * i -: 8] =
                              data_buffer_ff[63 - 8 * i -: 8] | ch;
                        end
                     end
                     data_count_in = data_count_ff + 4'd1;
                  end else begin
                     data_count_in = DATA_OVER;
                  end
               end
               default: begin
                  if (in_item.char_class == CLS_DIGIT) begin
                     check_acc_in = {check_acc_ff[12:0], 3'b000} +
                                    {check_acc_ff[14:0], 1'b0} +
                                    {12'd0, in_item.digit};
                     digits_seen_in[1] = 1'b1;
                  end
               end
            endcase
         end
      end

      // The result reflects the state after the last character is applied.
      out_item.accepted = (field_index_in == LAST_FIELD) && header_ok_in &&
                          (header_pos_in == HEADER_LEN) && (digits_seen_in == 2'b11) &&
                          (data_count_in != 4'd0) &&
                          (check_acc_in == {8'd0, running_xor_in});
      out_item.command_number = number_negative_in ? -$signed(number_acc_in)
                                                   : $signed(number_acc_in);
      out_item.data_text      = data_buffer_in;
      out_item.data_length    = (data_count_in > DATA_MAX) ? DATA_MAX : data_count_in;
      out_item.data_truncated = (data_count_in > DATA_MAX);

      if (out_push) begin
         field_index_in     = '0;
         running_xor_in     = '0;
         header_pos_in      = '0;
         header_ok_in       = 1'b1;
         number_acc_in      = '0;
         number_negative_in = 1'b0;
         check_acc_in       = '0;
         digits_seen_in     = '0;
         data_buffer_in     = '0;
         data_count_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff     <= '0;
         running_xor_ff     <= '0;
         header_pos_ff      <= '0;
         header_ok_ff       <= 1'b1;
         number_acc_ff      <= '0;
         number_negative_ff <= 1'b0;
         check_acc_ff       <= '0;
         digits_seen_ff     <= '0;
         data_buffer_ff     <= '0;
         data_count_ff      <= '0;
      end else begin
         field_index_ff     <= field_index_in;
         running_xor_ff     <= running_xor_in;
         header_pos_ff      <= header_pos_in;
         header_ok_ff       <= header_ok_in;
         number_acc_ff      <= number_acc_in;
         number_negative_ff <= number_negative_in;
         check_acc_ff       <= check_acc_in;
         digits_seen_ff     <= digits_seen_in;
         data_buffer_ff     <= data_buffer_in;
         data_count_ff      <= data_count_in;
      end
   end

endmodule

/* rtl/command_frame_parser_xor_check.sv */
// Top level of the command frame parser with XOR check.
//
// Takes one frame character per cycle and sustains one character per clock as long as the
// result queue has room; a frame's last character is held in the MID_DEPTH queue and its
// result in the RSP_DEPTH queue before it appears on rsp_data. A classifier feeds the first
// queue, which the field parser drains at one word per cycle, its state update setting the
// rate; the parser stalls only while the result queue is full. The header word is written
// through csr_write_en and csr_write_data and must change only while idle.
module command_frame_parser_xor_check #(
   parameter int DATA_CHARS = 8,
   parameter int MID_DEPTH  = 4,
   parameter int RSP_DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  cfpx_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cfpx_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [31:0]       csr_write_data
);
   import cfpx_pkg::*;

   logic [31:0] header_word_ff, header_word_in;
   item_type    front_item;
   item_type    mid_item;
   logic        mid_empty, mid_pop;
   rsp_type     back_rsp;
   logic        rsp_push, rsp_full;

   assign header_word_in = csr_write_en ? csr_write_data : header_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_word_ff <= HEADER_RESET;
      end else begin
         header_word_ff <= header_word_in;
      end
   end

   cfpx_front u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   cfpx_queue #(
      .WIDTH ($bits(item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_item),
      .full    (req_full),
      .pop     (mid_pop),
      .rd_data (mid_item),
      .empty   (mid_empty)
   );

   cfpx_back #(
      .DATA_CHARS (DATA_CHARS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .header_word (header_word_ff),
      .in_empty    (mid_empty),
      .in_item     (mid_item),
      .in_pop      (mid_pop),
      .out_full    (rsp_full),
      .out_push    (rsp_push),
      .out_item    (back_rsp)
   );

   cfpx_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

`ifndef SYNTHESIS
   // An accepted character must be waiting for the parser on the next cycle.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full |=> !mid_empty)
      else $error("accepted word did not reach the parser queue");

   // The last character of a frame always produces a result.
   a_frame_end_result: assert property (@(posedge clock) disable iff (reset)
      mid_pop && mid_item.frame_end |-> rsp_push)
      else $error("frame end consumed without a result");

   // The parser never pushes a result into a full result queue.
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");
`endif

endmodule
